// ===== rtl/core/pvk_pkg.sv =====
package pvk_pkg;

    localparam int SqrtSteps = 32;
    localparam int ExpTerms  = 12;
    localparam int PowSteps  = 11;

    // exp(-1) in Q.30, from the same truncating series as the datapath
    localparam logic [29:0] EM1_Q30 = 30'd395007543;

    typedef enum logic [1:0] {
        KV_CALC,
        KV_ONE,
        KV_ZERO
    } t_kv_mode;

    typedef struct packed {
        logic               halve;
        logic signed [23:0] vterm;
    } t_sq_side;

    typedef struct packed {
        t_kv_mode    mode;
        logic [3:0]  n;
    } t_exp_tag;

    // ceil(2^35 / k): exact floor division for dividends below 2^31
    function automatic logic [35:0] recip_q35(input int unsigned k);
        logic [35:0] m;
        case (k)
            1:       m = 36'd34359738368;
            2:       m = 36'd17179869184;
            3:       m = 36'd11453246123;
            4:       m = 36'd8589934592;
            5:       m = 36'd6871947674;
            6:       m = 36'd5726623062;
            7:       m = 36'd4908534053;
            8:       m = 36'd4294967296;
            9:       m = 36'd3817748708;
            10:      m = 36'd3435973837;
            11:      m = 36'd3123612579;
            12:      m = 36'd2863311531;
            default: m = 36'd0;
        endcase
        return m;
    endfunction

endpackage

// ===== rtl/core/pose_view_kernel_eval_core.sv =====
// Pose/view kernel evaluator. Each request carries a stored point and a query
// point (Q16.16 positions, Q1.14 view directions) and returns
// exp(-(pos_rate*|p_train - p_query| + 8*(1 - dot(v_train, v_query)))) as an
// unsigned Q1.16 weight, 65536 = 1.0. A zero or negative exponent gives 65536,
// an exponent of 12.0 or more gives 0. One request is taken every cycle while
// the pipe is not stalled. Its depth is set by the 32-stage square root and the
// 12-term exp series (two stages per term) followed by up to 11 multiplications
// by exp(-1). The whole pipe advances together: it holds when a result is
// waiting and the sink is not ready, and input ready follows that same condition.
// pos_rate (unsigned Q16.16, reset 0.6) is written through i_cfg_we/i_cfg_wdata
// by the user only while the pipe is empty; the block does not enforce this.
module pose_view_kernel_eval_core
    import pvk_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [31:0]        i_cfg_wdata,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [31:0] i_train_px,
    input  logic signed [31:0] i_train_py,
    input  logic signed [31:0] i_train_pz,
    input  logic signed [15:0] i_train_vx,
    input  logic signed [15:0] i_train_vy,
    input  logic signed [15:0] i_train_vz,
    input  logic signed [31:0] i_query_px,
    input  logic signed [31:0] i_query_py,
    input  logic signed [31:0] i_query_pz,
    input  logic signed [15:0] i_query_vx,
    input  logic signed [15:0] i_query_vy,
    input  logic signed [15:0] i_query_vz,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [16:0]        o_kernel_value
);

    localparam logic signed [50:0] E_CUTOFF = 51'sd12 <<< 16;

    logic en;
    logic [31:0] r_pos_rate;

    // stage 1: magnitudes of position deltas, view products
    logic signed [31:0] tp [3];
    logic signed [31:0] qp [3];
    logic signed [15:0] tv [3];
    logic signed [15:0] qv [3];
    logic signed [32:0] dlt [3];
    logic [32:0]        dmag [3];
    logic               halve;
    logic               r1_vld;
    logic [30:0]        r1_ad [3];
    logic               r1_halve;
    logic signed [31:0] r1_vp [3];

    // stage 2: squares, view term
    logic               r2_vld;
    logic [61:0]        r2_sq [3];
    logic               r2_halve;
    logic signed [23:0] r2_vterm;
    logic signed [33:0] dot;
    logic signed [33:0] vdiff;

    // stage 3: sum of squares
    logic               r3_vld;
    logic [63:0]        r3_sum;
    t_sq_side           r3_side;

    // square root
    logic               sq_vld;
    logic [31:0]        sq_root;
    t_sq_side           sq_side;
    logic [32:0]        pos_dist;

    // stage A/B/C: position term and total exponent
    logic               ra_vld;
    logic [48:0]        ra_hi;
    logic [47:0]        ra_lo;
    logic signed [23:0] ra_vterm;
    logic               rb_vld;
    logic [49:0]        rb_pterm;
    logic signed [23:0] rb_vterm;
    logic               rc_vld;
    logic signed [50:0] rc_e;
    t_exp_tag           ex_tag;

    assign en         = !o_out_valid || i_out_ready;
    assign o_in_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_rate <= 32'd39322;
        end else if (i_cfg_we) begin
            r_pos_rate <= i_cfg_wdata;
        end
    end

    assign tp = '{i_train_px, i_train_py, i_train_pz};
    assign qp = '{i_query_px, i_query_py, i_query_pz};
    assign tv = '{i_train_vx, i_train_vy, i_train_vz};
    assign qv = '{i_query_vx, i_query_vy, i_query_vz};

    always_comb begin
        halve = 1'b0;
        for (int i = 0; i < 3; i++) begin
            dlt[i]  = 33'(tp[i]) - 33'(qp[i]);
            dmag[i] = dlt[i][32] ? 33'(-dlt[i]) : 33'(dlt[i]);
            if (dmag[i][32:31] != 2'b00) begin
                halve = 1'b1;
            end
        end
    end

    // valid chain of stages 1 to 3 and A to C
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            ra_vld <= 1'b0;
            rb_vld <= 1'b0;
            rc_vld <= 1'b0;
        end else if (en) begin
            r1_vld <= i_in_valid;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            ra_vld <= sq_vld;
            rb_vld <= ra_vld;
            rc_vld <= rb_vld;
        end
    end

    assign dot   = 34'(r1_vp[0]) + 34'(r1_vp[1]) + 34'(r1_vp[2]);
    assign vdiff = (34'sd1 <<< 28) - dot;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r1_ad[i] <= halve ? dmag[i][31:1] : dmag[i][30:0];
                r1_vp[i] <= 32'(tv[i]) * 32'(qv[i]);
                r2_sq[i] <= 62'(r1_ad[i]) * 62'(r1_ad[i]);
            end
            r1_halve <= halve;
            r2_halve <= r1_halve;
            // 8*(1-dot) in Q16.16, floor
            r2_vterm <= 24'(vdiff >>> 9);
            r3_sum   <= 64'(r2_sq[0]) + 64'(r2_sq[1]) + 64'(r2_sq[2]);
            r3_side  <= '{halve: r2_halve, vterm: r2_vterm};
        end
    end

    pvk_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r3_vld),
        .i_value (r3_sum),
        .i_side  (r3_side),
        .o_valid (sq_vld),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    assign pos_dist = sq_side.halve ? {sq_root, 1'b0} : {1'b0, sq_root};

    always_ff @(posedge i_clk) begin
        if (en) begin
            ra_hi    <= 49'(r_pos_rate) * 49'(pos_dist[32:16]);
            ra_lo    <= 48'(r_pos_rate) * 48'(pos_dist[15:0]);
            ra_vterm <= sq_side.vterm;
            rb_pterm <= 50'(ra_hi) + 50'(ra_lo[47:16]);
            rb_vterm <= ra_vterm;
            rc_e     <= $signed({1'b0, rb_pterm}) + 51'(rb_vterm);
        end
    end

    always_comb begin
        ex_tag.n = rc_e[19:16];
        if (rc_e <= 51'sd0) begin
            ex_tag.mode = KV_ONE;
        end else if (rc_e >= E_CUTOFF) begin
            ex_tag.mode = KV_ZERO;
        end else begin
            ex_tag.mode = KV_CALC;
        end
    end

    pvk_exp u_exp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (en),
        .i_valid        (rc_vld),
        .i_tag          (ex_tag),
        .i_frac         (rc_e[15:0]),
        .o_valid        (o_out_valid),
        .o_kernel_value (o_kernel_value)
    );

`ifndef SYNTHESIS
    a_kv_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_kernel_value <= 17'd65536)
        else $error("kernel value above 1.0");

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("request taken while result stalled");

    a_stall_holds_exp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rc_vld && o_out_valid && !i_out_ready) |=> rc_vld && $stable(rc_e))
        else $error("exponent stage moved during stall");
`endif

endmodule

// ===== rtl/core/pvk_sqrt.sv =====
module pvk_sqrt
    import pvk_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  logic [63:0] i_value,
    input  t_sq_side    i_side,
    output logic        o_valid,
    output logic [31:0] o_root,
    output t_sq_side    o_side
);

    // one result bit per stage
    logic        r_vld  [SqrtSteps];
    logic [63:0] r_rem  [SqrtSteps];
    logic [63:0] r_res  [SqrtSteps];
    t_sq_side    r_side [SqrtSteps];

    for (genvar k = 0; k < SqrtSteps; k++) begin : g_step
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
        logic        vld_in;
        logic [63:0] rem_in;
        logic [63:0] res_in;
        logic [63:0] trial;
        t_sq_side    side_in;

        if (k == 0) begin : g_first
            assign vld_in  = i_valid;
            assign rem_in  = i_value;
            assign res_in  = 64'd0;
            assign side_in = i_side;
        end else begin : g_next
            assign vld_in  = r_vld[k-1];
            assign rem_in  = r_rem[k-1];
            assign res_in  = r_res[k-1];
            assign side_in = r_side[k-1];
        end

        assign trial = res_in + BIT;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[k] <= side_in;
                if (rem_in >= trial) begin
                    r_rem[k] <= rem_in - trial;
                    r_res[k] <= (res_in >> 1) + BIT;
                end else begin
                    r_rem[k] <= rem_in;
                    r_res[k] <= res_in >> 1;
                end
            end
        end
    end

    assign o_valid = r_vld[SqrtSteps-1];
    assign o_root  = r_res[SqrtSteps-1][31:0];
    assign o_side  = r_side[SqrtSteps-1];

endmodule

// ===== rtl/core/pvk_exp.sv =====
module pvk_exp
    import pvk_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  t_exp_tag    i_tag,
    input  logic [15:0] i_frac,
    output logic        o_valid,
    output logic [16:0] o_kernel_value
);

    localparam logic [30:0] Q30_ONE = 31'd1 << 30;

    // entry stage
    logic        r0_vld;
    logic [29:0] r0_x;
    t_exp_tag    r0_tag;

    // series: two stages per term
    logic               r_a_vld [1:ExpTerms];
    logic [30:0]        r_a_q   [1:ExpTerms];
    logic signed [32:0] r_a_s   [1:ExpTerms];
    logic [29:0]        r_a_x   [1:ExpTerms];
    t_exp_tag           r_a_tag [1:ExpTerms];
    logic               r_b_vld [1:ExpTerms];
    logic [30:0]        r_b_t   [1:ExpTerms];
    logic signed [32:0] r_b_s   [1:ExpTerms];
    logic [29:0]        r_b_x   [1:ExpTerms];
    t_exp_tag           r_b_tag [1:ExpTerms];

    // final sum
    logic               r_s_vld;
    logic [30:0]        r_s_r;
    t_exp_tag           r_s_tag;
    logic signed [32:0] s_final;

    // powers of exp(-1)
    logic               r_p_vld [PowSteps];
    logic [30:0]        r_p_r   [PowSteps];
    t_exp_tag           r_p_tag [PowSteps];

    logic               r_out_vld;
    logic [16:0]        r_out_kv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
        end else if (i_en) begin
            r0_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0_x   <= {i_frac, 14'd0};
            r0_tag <= i_tag;
        end
    end

    for (genvar k = 1; k <= ExpTerms; k++) begin : g_term
        localparam logic [35:0] RECIP = recip_q35(k);
        logic               vld_in;
        logic [30:0]        t_in;
        logic signed [32:0] s_in;
        logic [29:0]        x_in;
        t_exp_tag           tag_in;
        logic [60:0]        prod_a;
        logic [66:0]        prod_b;

        if (k == 1) begin : g_first
            assign vld_in = r0_vld;
            assign t_in   = Q30_ONE;
            assign s_in   = 33'sd1 <<< 30;
            assign x_in   = r0_x;
            assign tag_in = r0_tag;
        end else begin : g_next
            assign vld_in = r_b_vld[k-1];
            assign t_in   = r_b_t[k-1];
            // fold in the previous term: odd terms subtract
            if ((k - 1) % 2 == 1) begin : g_sub
                assign s_in = r_b_s[k-1] - $signed({2'b00, r_b_t[k-1]});
            end else begin : g_add
                assign s_in = r_b_s[k-1] + $signed({2'b00, r_b_t[k-1]});
            end
            assign x_in   = r_b_x[k-1];
            assign tag_in = r_b_tag[k-1];
        end

        assign prod_a = 61'(t_in) * 61'(x_in);
        assign prod_b = 67'(r_a_q[k]) * 67'(RECIP);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_a_vld[k] <= 1'b0;
                r_b_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_a_vld[k] <= vld_in;
                r_b_vld[k] <= r_a_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_a_q[k]   <= prod_a[60:30];
                r_a_s[k]   <= s_in;
                r_a_x[k]   <= x_in;
                r_a_tag[k] <= tag_in;
                r_b_t[k]   <= 31'(prod_b >> 35);
                r_b_s[k]   <= r_a_s[k];
                r_b_x[k]   <= r_a_x[k];
                r_b_tag[k] <= r_a_tag[k];
            end
        end
    end

    // last term has even index: add
    assign s_final = r_b_s[ExpTerms] + $signed({2'b00, r_b_t[ExpTerms]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_vld <= 1'b0;
        end else if (i_en) begin
            r_s_vld <= r_b_vld[ExpTerms];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s_r   <= s_final[32] ? 31'd0 : s_final[30:0];
            r_s_tag <= r_b_tag[ExpTerms];
        end
    end

    for (genvar j = 0; j < PowSteps; j++) begin : g_pow
        logic        vld_in;
        logic [30:0] r_in;
        t_exp_tag    tag_in;
        logic [59:0] prod;

        if (j == 0) begin : g_first
            assign vld_in = r_s_vld;
            assign r_in   = r_s_r;
            assign tag_in = r_s_tag;
        end else begin : g_next
            assign vld_in = r_p_vld[j-1];
            assign r_in   = r_p_r[j-1];
            assign tag_in = r_p_tag[j-1];
        end

        // round half up in Q.30
        assign prod = 60'(r_in) * 60'(EM1_Q30) + (60'd1 << 29);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_p_vld[j] <= 1'b0;
            end else if (i_en) begin
                r_p_vld[j] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_p_r[j]   <= (tag_in.n > 4'(j)) ? 31'(prod >> 30) : r_in;
                r_p_tag[j] <= tag_in;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_en) begin
            r_out_vld <= r_p_vld[PowSteps-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            case (r_p_tag[PowSteps-1].mode)
                KV_ONE:  r_out_kv <= 17'd65536;
                KV_ZERO: r_out_kv <= 17'd0;
                default: r_out_kv <= 17'((r_p_r[PowSteps-1] + (31'd1 << 13)) >> 14);
            endcase
        end
    end

    assign o_valid        = r_out_vld;
    assign o_kernel_value = r_out_kv;

endmodule

// ===== tb/tb_pose_view_kernel_eval_core.sv =====
module tb_pose_view_kernel_eval_core;
    import pvk_pkg::*;

    // One pair of points: stored and query positions and views.
    typedef struct {
        logic signed [31:0] tp [3];
        logic signed [15:0] tv [3];
        logic signed [31:0] qp [3];
        logic signed [15:0] qv [3];
    } t_pair;

    // ------------------------------------------------------------------
    // Kernel weight predictor and pending-weight store
    // ------------------------------------------------------------------
    class kernel_scoreboard;
        logic [31:0] rate;
        logic [16:0] pending [$];
        int          n_err;

        function new();
            rate  = 32'd39322;
            n_err = 0;
        endfunction

        // floor sqrt, bitwise restoring method
        function logic [63:0] floor_sqrt(input logic [63:0] v);
            logic [63:0] rem, res, b;
            rem = v;
            res = 0;
            b   = 64'd1 << 62;
            while (b > rem) b = b >> 2;
            while (b != 0) begin
                if (rem >= res + b) begin
                    rem = rem - (res + b);
                    res = (res >> 1) + b;
                end else begin
                    res = res >> 1;
                end
                b = b >> 2;
            end
            return res;
        endfunction

        // exp(-x), x in Q.30 within [0,1], truncating 12-term series
        function logic [63:0] series_exp(input logic [63:0] x);
            logic [63:0] t;
            longint      s;
            t = 64'd1 << 30;
            s = 64'sd1 << 30;
            for (int k = 1; k <= 12; k++) begin
                t = ((t * x) >> 30) / k;
                if (k % 2 == 1) s = s - longint'(t);
                else            s = s + longint'(t);
            end
            return (s < 0) ? 64'd0 : 64'(s);
        endfunction

        function logic [16:0] weight(input t_pair p);
            logic [63:0] ad [3];
            logic [63:0] sq, pdist, pterm, r, em1;
            longint      d, dot, v, vterm, e;
            logic        halve;
            int          n;
            halve = 1'b0;
            for (int i = 0; i < 3; i++) begin
                d     = longint'(p.tp[i]) - longint'(p.qp[i]);
                ad[i] = (d < 0) ? 64'(-d) : 64'(d);
                if (ad[i] >= (64'd1 << 31)) halve = 1'b1;
            end
            if (halve) for (int i = 0; i < 3; i++) ad[i] = ad[i] >> 1;
            sq    = ad[0] * ad[0] + ad[1] * ad[1] + ad[2] * ad[2];
            pdist = floor_sqrt(sq);
            if (halve) pdist = pdist << 1;
            pterm = 64'(rate) * (pdist >> 16) + ((64'(rate) * (pdist & 64'hFFFF)) >> 16);
            dot = 0;
            for (int i = 0; i < 3; i++) dot += longint'(p.tv[i]) * longint'(p.qv[i]);
            v = (64'sd1 <<< 28) - dot;
            // 8*(1-dot), floored toward minus infinity
            vterm = v >>> 9;
            e = longint'(pterm) + vterm;
            if (e <= 0) return 17'd65536;
            if (e >= (64'sd12 <<< 16)) return 17'd0;
            n   = int'(e >> 16);
            r   = series_exp((64'(e) & 64'hFFFF) << 14);
            em1 = series_exp(64'd1 << 30);
            for (int i = 0; i < n; i++) r = (r * em1 + (64'd1 << 29)) >> 30;
            return 17'((r + (64'd1 << 13)) >> 14);
        endfunction

        function void note_request(input t_pair p);
            pending.push_back(weight(p));
        endfunction

        function void check_result(input logic [16:0] got);
            logic [16:0] want;
            if (pending.size() == 0) begin
                $error("kernel_value: unexpected result %0d", got);
                n_err++;
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                $error("kernel_value: expected %0d actual %0d", want, got);
                n_err++;
            end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [31:0]        cfg_wdata = '0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic signed [31:0] tpx = '0, tpy = '0, tpz = '0, qpx = '0, qpy = '0, qpz = '0;
    logic signed [15:0] tvx = '0, tvy = '0, tvz = '0, qvx = '0, qvy = '0, qvz = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [16:0]        kval;

    kernel_scoreboard sb = new();
    bit               idle_on = 1'b1;
    int               quiet = 0;

    localparam int PIPE_LAT = 76;
    localparam int WATCHDOG = 5000;

    always #1 clk = ~clk;

    pose_view_kernel_eval_core u_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_wdata    (cfg_wdata),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_train_px     (tpx),
        .i_train_py     (tpy),
        .i_train_pz     (tpz),
        .i_train_vx     (tvx),
        .i_train_vy     (tvy),
        .i_train_vz     (tvz),
        .i_query_px     (qpx),
        .i_query_py     (qpy),
        .i_query_pz     (qpz),
        .i_query_vx     (qvx),
        .i_query_vy     (qvy),
        .i_query_vz     (qvz),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_kernel_value (kval)
    );

    // Sink: random stall bursts while idling is on, otherwise always ready.
    // Results are checked at the edge where the handshake completes.
    initial begin
        int gap;
        forever begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready) sb.check_result(kval);
            if (idle_on && $urandom_range(0, 5) == 0 && out_ready) begin
                out_ready <= 1'b0;
                gap = $urandom_range(1, 14);
                repeat (gap - 1) begin
                    @(posedge clk);
                end
                @(posedge clk);
                out_ready <= 1'b1;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // Watchdog: cycles with no handshake on either channel.
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet >= WATCHDOG) begin
            $display("FAIL");
            $finish;
        end
    end

    // Present one request and hold it until accepted. Valid stays up after
    // the handshake so the next request can follow back to back.
    task automatic send_pair(input t_pair p);
        int gap;
        if (idle_on && $urandom_range(0, 6) == 0) begin
            gap = $urandom_range(1, 14);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        tpx <= p.tp[0]; tpy <= p.tp[1]; tpz <= p.tp[2];
        tvx <= p.tv[0]; tvy <= p.tv[1]; tvz <= p.tv[2];
        qpx <= p.qp[0]; qpy <= p.qp[1]; qpz <= p.qp[2];
        qvx <= p.qv[0]; qvy <= p.qv[1]; qvz <= p.qv[2];
        do @(posedge clk); while (!in_ready);
        sb.note_request(p);
    endtask

    // Stop sending and let the pipe drain; set_rate then writes the rate register.
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (PIPE_LAT + 4) @(posedge clk);
    endtask

    task automatic set_rate(input logic [31:0] r);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= r;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.rate = r;
    endtask

    function automatic logic signed [15:0] rand_view();
        int c;
        c = $urandom_range(0, 9);
        if (c == 0) return 16'sd16384;
        if (c == 1) return -16'sd16384;
        if (c == 2) return 16'($urandom());      // out-of-range noise
        return 16'(int'($urandom_range(0, 32768)) - 16384);
    endfunction

    function automatic logic signed [31:0] rand_pos();
        int c;
        c = $urandom_range(0, 7);
        if (c == 0) return 32'($urandom());
        if (c == 1) return ($urandom_range(0, 1) != 0) ? 32'h7FFFFFFF : 32'h80000000;
        return 32'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
    endfunction

    function automatic t_pair rand_pair();
        t_pair p;
        for (int i = 0; i < 3; i++) begin
            p.tp[i] = rand_pos();
            p.tv[i] = rand_view();
            // mostly nearby query so the exponent stays in the live range
            if ($urandom_range(0, 3) == 0) p.qp[i] = rand_pos();
            else p.qp[i] = p.tp[i] + 32'(int'($urandom_range(0, 1 << 18)) - (1 << 17));
            if ($urandom_range(0, 2) == 0) p.qv[i] = rand_view();
            else p.qv[i] = p.tv[i] + 16'(int'($urandom_range(0, 2000)) - 1000);
        end
        return p;
    endfunction

    function automatic t_pair mk(input logic signed [31:0] tp, input logic signed [15:0] tv,
                                 input logic signed [31:0] qp, input logic signed [15:0] qv);
        t_pair p;
        for (int i = 0; i < 3; i++) begin
            p.tp[i] = tp; p.tv[i] = tv; p.qp[i] = qp; p.qv[i] = qv;
        end
        return p;
    endfunction

    initial begin
        t_pair p;
        logic [31:0] rates [5];
        rates = '{32'd1, 32'hFFFFFFFF, 32'd0, 32'd65536, 32'd39322};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: identical points with aligned views give exactly 1.0
        send_pair(mk(32'sd0, 16'sd16384, 32'sd0, 16'sd16384));
        p = mk(32'sd0, 16'sd0, 32'sd0, 16'sd0); p.tv[0] = 16'sd16384; p.qv[0] = 16'sd16384;
        send_pair(p);                                   // unit views, zero exponent
        send_pair(mk(32'sd0, 16'sd16384, 32'sd0, -16'sd16384)); // opposite views
        send_pair(mk(32'sd0, -16'sd16384, 32'sd0, -16'sd16384)); // negative exponent
        send_pair(mk(32'h7FFFFFFF, 16'sd0, 32'h80000000, 16'sd0)); // halving path
        send_pair(mk(32'h80000000, 16'sd16384, 32'h80000000, 16'sd16384));
        send_pair(mk(32'sd65536, 16'sd9459, 32'sd0, 16'sd9459)); // partial distance
        p = mk(32'sd0, 16'sd0, 32'sd0, 16'sd0); p.tv[0] = 16'sd16384; p.qv[1] = 16'sd16384;
        send_pair(p);                                   // orthogonal: exponent 8
        p = mk(32'sd0, 16'sd0, 32'sd0, 16'sd0); p.tv[0] = 16'sd16384; p.qv[0] = 16'sd14000;
        send_pair(p);                                   // exponent near 1.16
        p = mk(32'sd0, 16'sd0, 32'sd0, 16'sd0);
        p.tp[0] = 32'sd65536 * 11; p.tv[0] = 16'sd16384; p.qv[0] = 16'sd16384;
        send_pair(p);                                   // distance 11, exponent about 6.6
        send_pair(mk(32'h7FFFFFFF, 16'h7FFF, 32'h80000000, 16'h8000));
        send_pair(mk(-32'sd1, 16'hFFFF, 32'sd1, 16'h0001));

        // Sender waits for the pipe to empty at least once
        drain();

        // Rate sweep, extremes included; random traffic in each setting
        foreach (rates[k]) begin
            set_rate(rates[k]);
            for (int j = 0; j < 8; j++)
                send_pair(mk(32'sd65536 * j, 16'sd16384, 32'sd0, 16'sd16384));
            for (int j = 0; j < 200; j++) send_pair(rand_pair());
        end
        set_rate($urandom_range(20000, 200000));
        for (int j = 0; j < 150; j++) send_pair(rand_pair());

        // Final stretch with no idling on either side
        idle_on = 1'b0;
        for (int j = 0; j < 150; j++) send_pair(rand_pair());
        in_valid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge clk);
        repeat (PIPE_LAT + 10) @(posedge clk);
        if (sb.n_err == 0 && sb.pending.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
